>>> rtl/core/vec_pkg.sv
// Shared types and constants for the viewport edge clip block.
// No dependencies.
package vec_pkg;

  localparam int TW = 21;   // target coordinate width
  localparam int CW = 18;   // configuration register width
  localparam int OW = 23;   // operand width for products and divisors
  localparam int PW = 2 * OW;
  localparam int MW = 45;   // product magnitude width, one divider stage per bit
  localparam int DW = 23;   // divisor magnitude width
  localparam int SW = 48;   // post-divide arithmetic width
  localparam int IW = 3;    // register index width

  localparam logic [CW-1:0] WIDTH_RST  = CW'(30720);
  localparam logic [CW-1:0] HEIGHT_RST = CW'(17280);
  localparam logic [CW-1:0] REFX_RST   = CW'(15360);
  localparam logic [CW-1:0] REFY_RST   = CW'(8640);

  typedef enum logic [IW-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_REFX   = 3'd2,
    REG_REFY   = 3'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
  } cfg_t;

  typedef struct packed {
    logic                 west;
    logic                 east;
    logic                 north;
    logic                 south;
    logic signed [TW-1:0] tx;
  } side_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic [DW-1:0] dm;
    logic          neg;
    logic          dz;
  } dop_t;

  typedef struct packed {
    logic [MW-1:0] quo;
    logic          neg;
    logic          dz;
  } dres_t;

endpackage

>>> rtl/core/viewport_edge_clip_top.sv
// Viewport edge clip: one transfer in per cycle while in_stall_o is low, one result per
// target. Inputs pass two classification and product registers, the two 45-stage
// divider lanes with one quotient bit per stage, and the output register.
// Depends on vec_pkg, vec_prep, vec_div and vec_post.
module viewport_edge_clip_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vec_pkg::IW-1:0]        cfg_idx_i,
  input  logic [vec_pkg::CW-1:0]        cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [vec_pkg::TW-1:0] target_x_i,
  input  logic signed [vec_pkg::TW-1:0] target_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          clipped_o,
  output logic [vec_pkg::CW-1:0]        edge_x_o,
  output logic [vec_pkg::CW-1:0]        edge_y_o
);
  import vec_pkg::*;

  cfg_t  cfg_q;
  logic  prep_rdy, p_valid, d_rdy, d_valid, post_rdy;
  dop_t  op1, op2;
  side_t p_side, d_side;
  dres_t res1, res2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{w: WIDTH_RST, h: HEIGHT_RST, rx: REFX_RST, ry: REFY_RST};
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH:  cfg_q.w  <= cfg_wdata_i;
        REG_HEIGHT: cfg_q.h  <= cfg_wdata_i;
        REG_REFX:   cfg_q.rx <= cfg_wdata_i;
        REG_REFY:   cfg_q.ry <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = !prep_rdy;

  vec_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_valid_i),
    .rdy_o   (prep_rdy),
    .tx_i    (target_x_i),
    .ty_i    (target_y_i),
    .valid_o (p_valid),
    .rdy_i   (d_rdy),
    .op1_o   (op1),
    .op2_o   (op2),
    .side_o  (p_side)
  );

  vec_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (p_valid),
    .rdy_o   (d_rdy),
    .op1_i   (op1),
    .op2_i   (op2),
    .side_i  (p_side),
    .valid_o (d_valid),
    .rdy_i   (post_rdy),
    .res1_o  (res1),
    .res2_o  (res2),
    .side_o  (d_side)
  );

  vec_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (d_valid),
    .rdy_o       (post_rdy),
    .res1_i      (res1),
    .res2_i      (res2),
    .side_i      (d_side),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .clipped_o   (clipped_o),
    .edge_x_o    (edge_x_o),
    .edge_y_o    (edge_y_o)
  );

endmodule

>>> rtl/core/vec_prep.sv
// Classification, operand selection and product stages.
// Depends on vec_pkg.
module vec_prep (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  vec_pkg::cfg_t                cfg_i,
  input  logic                         valid_i,
  output logic                         rdy_o,
  input  logic signed [vec_pkg::TW-1:0] tx_i,
  input  logic signed [vec_pkg::TW-1:0] ty_i,
  output logic                         valid_o,
  input  logic                         rdy_i,
  output vec_pkg::dop_t                op1_o,
  output vec_pkg::dop_t                op2_o,
  output vec_pkg::side_t               side_o
);
  import vec_pkg::*;

  logic                 v1_q, v2_q, r1, r2;
  logic signed [OW-1:0] a1_d, b1_d, c1_d, a2_d, b2_d, c2_d;
  logic signed [OW-1:0] a1_q, b1_q, c1_q, a2_q, b2_q, c2_q;
  side_t                side_d, side1_q, side2_q;
  dop_t                 op1_d, op2_d, op1_q, op2_q;
  logic signed [OW-1:0] txe, tye, we, he, rxe, rye;
  logic signed [PW-1:0] p1, p2, m1, m2;
  logic signed [OW-1:0] d1, d2;

  assign r2    = !v2_q || rdy_i;
  assign r1    = !v1_q || r2;
  assign rdy_o = r1;

  always_comb begin
    txe = OW'(tx_i);
    tye = OW'(ty_i);
    we  = $signed({{(OW-CW){1'b0}}, cfg_i.w});
    he  = $signed({{(OW-CW){1'b0}}, cfg_i.h});
    rxe = $signed({{(OW-CW){1'b0}}, cfg_i.rx});
    rye = $signed({{(OW-CW){1'b0}}, cfg_i.ry});
    side_d.tx    = tx_i;
    side_d.west  = (txe <= 0);
    side_d.east  = !side_d.west && (txe >= we);
    side_d.north = (tye <= 0);
    side_d.south = !side_d.north && (tye >= he);
    a1_d = rxe;
    b1_d = tye - rye;
    c1_d = side_d.west ? (rxe - txe) : (txe - rxe);
    if ((side_d.west || side_d.east) && side_d.north) begin
      a2_d = tye;
      b2_d = rxe - txe;
      c2_d = rye - tye;
    end else if (side_d.north) begin
      a2_d = rye;
      b2_d = txe - rxe;
      c2_d = rye - tye;
    end else begin
      a2_d = rye;
      b2_d = txe - rxe;
      c2_d = tye - rye;
    end
  end

  always_comb begin
    p1 = PW'(a1_q) * PW'(b1_q);
    p2 = PW'(a2_q) * PW'(b2_q);
    m1 = p1[PW-1] ? -p1 : p1;
    m2 = p2[PW-1] ? -p2 : p2;
    d1 = c1_q[OW-1] ? -c1_q : c1_q;
    d2 = c2_q[OW-1] ? -c2_q : c2_q;
    op1_d.mag = m1[MW-1:0];
    op1_d.dm  = d1[DW-1:0];
    op1_d.neg = p1[PW-1] ^ c1_q[OW-1];
    op1_d.dz  = (c1_q == '0);
    op2_d.mag = m2[MW-1:0];
    op2_d.dm  = d2[DW-1:0];
    op2_d.neg = p2[PW-1] ^ c2_q[OW-1];
    op2_d.dz  = (c2_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (r1) v1_q <= valid_i;
      if (r2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) begin
      a1_q    <= a1_d;
      b1_q    <= b1_d;
      c1_q    <= c1_d;
      a2_q    <= a2_d;
      b2_q    <= b2_d;
      c2_q    <= c2_d;
      side1_q <= side_d;
    end
    if (r2) begin
      op1_q   <= op1_d;
      op2_q   <= op2_d;
      side2_q <= side1_q;
    end
  end

  assign valid_o = v2_q;
  assign op1_o   = op1_q;
  assign op2_o   = op2_q;
  assign side_o  = side2_q;

endmodule

>>> rtl/core/vec_div.sv
// Two-lane restoring divider, one quotient bit per pipeline stage.
// Depends on vec_pkg.
module vec_div (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           rdy_o,
  input  vec_pkg::dop_t  op1_i,
  input  vec_pkg::dop_t  op2_i,
  input  vec_pkg::side_t side_i,
  output logic           valid_o,
  input  logic           rdy_i,
  output vec_pkg::dres_t res1_o,
  output vec_pkg::dres_t res2_o,
  output vec_pkg::side_t side_o
);
  import vec_pkg::*;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [MW-1:0] quo;
    logic [DW-1:0] dm;
    logic          neg;
    logic          dz;
  } lane_t;

  function automatic lane_t div_step(lane_t l);
    logic [DW:0] t;
    lane_t       o;
    t     = {l.rem, l.quo[MW-1]};
    o     = l;
    o.quo = {l.quo[MW-2:0], 1'b0};
    if (t >= {1'b0, l.dm}) begin
      t        = t - {1'b0, l.dm};
      o.quo[0] = 1'b1;
    end
    o.rem = t[DW-1:0];
    return o;
  endfunction

  logic          v_q [MW];
  logic          rdy [MW+1];
  lane_t         l1_q [MW];
  lane_t         l2_q [MW];
  side_t         s_q [MW];
  lane_t         l1_in, l2_in;

  always_comb begin
    l1_in = '{rem: '0, quo: op1_i.mag, dm: op1_i.dm, neg: op1_i.neg, dz: op1_i.dz};
    l2_in = '{rem: '0, quo: op2_i.mag, dm: op2_i.dm, neg: op2_i.neg, dz: op2_i.dz};
  end

  assign rdy[MW] = rdy_i;

  for (genvar k = 0; k < MW; k++) begin : g_stage
    logic  v_in;
    lane_t a_in, b_in;
    side_t s_in;

    assign rdy[k] = !v_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign a_in = l1_in;
      assign b_in = l2_in;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign a_in = l1_q[k-1];
      assign b_in = l2_q[k-1];
      assign s_in = s_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        l1_q[k] <= div_step(a_in);
        l2_q[k] <= div_step(b_in);
        s_q[k]  <= s_in;
      end
    end
  end

  assign rdy_o   = rdy[0];
  assign valid_o = v_q[MW-1];
  assign side_o  = s_q[MW-1];
  assign res1_o  = '{quo: l1_q[MW-1].quo, neg: l1_q[MW-1].neg, dz: l1_q[MW-1].dz};
  assign res2_o  = '{quo: l2_q[MW-1].quo, neg: l2_q[MW-1].neg, dz: l2_q[MW-1].dz};

endmodule

>>> rtl/core/vec_post.sv
// Edge selection, range check and output register.
// Depends on vec_pkg.
module vec_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  vec_pkg::cfg_t        cfg_i,
  input  logic                 valid_i,
  output logic                 rdy_o,
  input  vec_pkg::dres_t       res1_i,
  input  vec_pkg::dres_t       res2_i,
  input  vec_pkg::side_t       side_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 clipped_o,
  output logic [vec_pkg::CW-1:0] edge_x_o,
  output logic [vec_pkg::CW-1:0] edge_y_o
);
  import vec_pkg::*;

  logic                 v_q, clip_d, clip_q, ok, we_cls;
  logic signed [SW-1:0] q1, q2, y1, x2, x, y, ws, hs, rxs, rys;
  logic [CW-1:0]        ex_d, ey_d, ex_q, ey_q;

  assign rdy_o = !v_q || !out_stall_i;

  always_comb begin
    ws  = $signed({{(SW-CW){1'b0}}, cfg_i.w});
    hs  = $signed({{(SW-CW){1'b0}}, cfg_i.h});
    rxs = $signed({{(SW-CW){1'b0}}, cfg_i.rx});
    rys = $signed({{(SW-CW){1'b0}}, cfg_i.ry});
    q1  = $signed({{(SW-MW){1'b0}}, res1_i.quo});
    q2  = $signed({{(SW-MW){1'b0}}, res2_i.quo});
    if (res1_i.neg) q1 = -q1;
    if (res2_i.neg) q2 = -q2;
    we_cls = side_i.west || side_i.east;
    y1 = rys + q1;
    x2 = (we_cls && side_i.north) ? (SW'(side_i.tx) - q2) : (rxs + q2);
    if (we_cls) begin
      ok = !res1_i.dz;
      x  = side_i.west ? '0 : ws;
      y  = y1;
      if (ok && side_i.north && y1 < 0) begin
        y  = '0;
        x  = x2;
        ok = !res2_i.dz;
      end else if (ok && side_i.south && y1 > hs) begin
        y  = hs;
        x  = x2;
        ok = !res2_i.dz;
      end
    end else begin
      ok = !res2_i.dz && side_i.north != side_i.south;
      y  = side_i.north ? '0 : hs;
      x  = x2;
    end
    clip_d = ok && (x >= 0) && (x <= ws) && (y >= 0) && (y <= hs);
    ex_d   = clip_d ? x[CW-1:0] : '0;
    ey_d   = clip_d ? y[CW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (rdy_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o) begin
      clip_q <= clip_d;
      ex_q   <= ex_d;
      ey_q   <= ey_d;
    end
  end

  assign out_valid_o = v_q;
  assign clipped_o   = clip_q;
  assign edge_x_o    = ex_q;
  assign edge_y_o    = ey_q;

endmodule
